### rtl/core/cbdc_pkg.sv
`default_nettype none
package cbdc_pkg;

   localparam int MaxStringBytes = 256;

   localparam logic [2:0] MODE_ASCII   = 3'd0;
   localparam logic [2:0] MODE_EUC     = 3'd2;
   localparam logic [2:0] MODE_EBCDIC  = 3'd4;
   localparam logic [2:0] MODE_EBCDIK  = 3'd5;
   localparam logic [2:0] MODE_RAW_TOP = 3'd7;

   typedef enum logic [1:0] {
      KIND_NONE = 2'd0,
      KIND_LEAD = 2'd1,
      KIND_KANA = 2'd2
   } kind_type;

   // One classified request: up to two result bytes and their flags.
   typedef struct packed {
      logic       two;
      logic [7:0] byte0;
      logic       valid0;
      logic [7:0] byte1;
      logic       eos;
   } work_type;

   localparam logic [2047:0] EbcdicRom =
      2048'h0000000000000000000000000000000000000000000000000000000000000000000000000000000000000000000000000000000000000000000000000000000020000000000000000000002e3c282b7c2600000000000000000021242a293b002d2f0000000000000000002c255f3e3f000000000000000000603a2340273d2200616263646566676869000000000000006a6b6c6d6e6f707172000000000000007e737475767778797a000000000000000000000000000000000000000000007b4142434445464748490000000000007d4a4b4c4d4e4f5051520000000000005c00535455565758595a00000000000030313233343536373839000000000000;
   localparam logic [2047:0] EbcdikRom =
      2048'h0000000000000000000000000000000000000000000000000000000000000000000000000000000000000000000000000000000000000000000000000000000020a1a2a3a4a5a6a7a8a9002e3c282b7c26aaabacadaeaf00b000215c2a293b002d2f0000000000000000002c255f3e3f000000000000000000603a2340273d2200b1b2b3b4b5b6b7b8b9ba00bbbcbdbebfc0c1c2c3c4c5c6c7c8c90000cacbcc0000cdcecfd0d1d2d3d4d500d6d7d8d900000000000000000000dadbdcdddedf00414243444546474849000000000000004a4b4c4d4e4f5051520000000000002400535455565758595a00000000000030313233343536373839000000000000;

   function automatic logic [7:0] rom_read(input logic [2047:0] rom, input logic [7:0] b);
      logic [7:0] t;
      t = rom[2047 - 8*b -: 8];
      return t;
   endfunction

   function automatic logic [7:0] ascii_show(input logic [7:0] b);
      return (b >= 8'h20 && b <= 8'h7e) ? b : 8'h2e;
   endfunction

endpackage
`default_nettype wire

### rtl/core/cbdc_front.sv
`default_nettype none
module cbdc_front
   import cbdc_pkg::*;
#(
   parameter int MAX_STRING_BYTES = MaxStringBytes
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic [2:0] csr_charset_mode,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   output logic            wk_valid,
   input  wire logic       wk_ready,
   output work_type        wk_data
);
   localparam int CW = $clog2(MAX_STRING_BYTES + 1);

   logic [2:0]    mode_ff;
   kind_type      kind_ff, kind_in;
   logic [7:0]    lead_ff, lead_in;
   logic [CW-1:0] seen_ff, seen_in;
   logic          drop_ff, drop_in;
   logic          fire;
   logic          at_end;
   logic [1:0]    cnt;
   logic [7:0]    o0, o1;
   logic          v0;
   logic [7:0]    hi, lo, t, s, rb;
   logic          fresh;

   // The front stalls only on the queue; a two byte request is one entry.
   assign req_ready = wk_ready;
   assign wk_valid  = req_valid;
   assign fire      = req_valid && wk_ready;

   always_comb begin
      kind_in = kind_ff;
      lead_in = lead_ff;
      seen_in = seen_ff;
      drop_in = drop_ff;
      cnt = 2'd0;
      o0 = 8'h00;
      o1 = 8'h00;
      v0 = 1'b1;
      at_end = 1'b0;
      fresh = 1'b1;
      hi = lead_ff - 8'h80;
      lo = req_data_byte - 8'h80;
      if (!hi[0]) lo = lo + 8'h7e;
      else if (lo < 8'h60) lo = lo + 8'h1f;
      else lo = lo + 8'h20;
      t = (hi - 8'h21) >> 1;
      s = t + 8'h81;
      if (s > 8'h9f) s = t + 8'hc1;
      rb = (mode_ff == MODE_EBCDIC) ? rom_read(EbcdicRom, req_data_byte)
                                    : rom_read(EbcdikRom, req_data_byte);
      if (!drop_ff) begin
         if (seen_ff < CW'(MAX_STRING_BYTES)) seen_in = seen_ff + 1'b1;
         at_end = req_last_byte || (seen_in >= CW'(MAX_STRING_BYTES));
         if (at_end && !req_last_byte) drop_in = 1'b1;
         kind_in = KIND_NONE;
         if (mode_ff == MODE_EUC) begin
            if (kind_ff == KIND_LEAD) begin
               if (req_data_byte >= 8'ha1 && req_data_byte <= 8'hfe) begin
                  o0 = s; o1 = lo; cnt = 2'd2; fresh = 1'b0;
               end else begin
                  o0 = 8'h2e; cnt = 2'd1;
               end
            end else if (kind_ff == KIND_KANA) begin
               if (req_data_byte >= 8'ha1 && req_data_byte <= 8'hdf) begin
                  o0 = req_data_byte; cnt = 2'd1; fresh = 1'b0;
               end else begin
                  o0 = 8'h8e; cnt = 2'd1;
               end
            end
            if (fresh) begin
               if (req_data_byte >= 8'ha1 && req_data_byte <= 8'hfe) begin
                  if (at_end) begin
                     if (cnt == 2'd0) o0 = 8'h2e; else o1 = 8'h2e;
                     cnt = cnt + 2'd1;
                  end else begin
                     kind_in = KIND_LEAD;
                     lead_in = req_data_byte;
                  end
               end else if (req_data_byte == 8'h8e) begin
                  if (!at_end) kind_in = KIND_KANA;
               end else begin
                  if (cnt == 2'd0) o0 = ascii_show(req_data_byte);
                  else o1 = ascii_show(req_data_byte);
                  cnt = cnt + 2'd1;
               end
            end
         end else begin
            cnt = 2'd1;
            case (mode_ff)
               MODE_ASCII:  o0 = ascii_show(req_data_byte);
               MODE_EBCDIC,
               MODE_EBCDIK: o0 = (rb != 8'h00) ? rb : 8'h2e;
               default:     o0 = req_data_byte;
            endcase
         end
      end
      if (req_last_byte) begin
         if (cnt == 2'd0) begin
            v0 = 1'b0; o0 = 8'h00; cnt = 2'd1;
         end
         kind_in = KIND_NONE;
         lead_in = 8'h00;
         seen_in = '0;
         drop_in = 1'b0;
      end
   end

   // A request that yields nothing and is not last still passes as a
   // zero-length entry; the back end discards it.
   always_comb begin
      wk_data.two    = (cnt == 2'd2);
      wk_data.byte0  = o0;
      wk_data.valid0 = v0 && (cnt != 2'd0);
      wk_data.byte1  = o1;
      wk_data.eos    = req_last_byte;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_ASCII;
         kind_ff <= KIND_NONE;
         lead_ff <= 8'h00;
         seen_ff <= '0;
         drop_ff <= 1'b0;
      end else begin
         if (fire) begin
            kind_ff <= kind_in;
            lead_ff <= lead_in;
            seen_ff <= seen_in;
            drop_ff <= drop_in;
         end
         if (csr_write_enable) begin
            mode_ff <= csr_charset_mode;
            kind_ff <= KIND_NONE;
            lead_ff <= 8'h00;
         end
      end
   end
endmodule
`default_nettype wire

### rtl/core/cbdc_queue.sv
`default_nettype none
module cbdc_queue
   import cbdc_pkg::*;
(
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     in_valid,
   output logic          in_ready,
   input  wire work_type in_data,
   output logic          out_valid,
   input  wire logic     out_ready,
   output work_type      out_data
);
   // Two-entry queue; full throughput with registered ready.
   work_type   mem_ff [2];
   logic       wp_ff, rp_ff;
   logic [1:0] cnt_ff;
   logic       push, pop;

   assign in_ready  = (cnt_ff != 2'd2);
   assign out_valid = (cnt_ff != 2'd0);
   assign out_data  = mem_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop  = out_valid && out_ready;

   always_ff @(posedge clock) begin
      if (push) mem_ff[wp_ff] <= in_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff <= 1'b0; rp_ff <= 1'b0; cnt_ff <= 2'd0;
      end else begin
         if (push) wp_ff <= !wp_ff;
         if (pop) rp_ff <= !rp_ff;
         cnt_ff <= cnt_ff + {1'b0, push} - {1'b0, pop};
      end
   end

`ifndef ASSERT_OFF
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd2 |-> !push) else $error("queue overflow");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff == 2'd0 |-> !pop) else $error("queue underflow");
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> cnt_ff == $past(cnt_ff) + 2'd1) else $error("count");
`endif
endmodule
`default_nettype wire

### rtl/core/cbdc_back.sv
`default_nettype none
module cbdc_back
   import cbdc_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       wk_valid,
   output logic            wk_ready,
   input  wire work_type   wk_data,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_out_valid,
   output logic            rsp_end_of_string
);
   logic second_ff;
   logic empty;
   logic final_beat;

   // Entries with no byte and no end marker are dropped without a beat.
   assign empty      = !wk_data.valid0 && !wk_data.eos;
   assign final_beat = !wk_data.two || second_ff;
   assign rsp_valid  = wk_valid && !empty;
   assign wk_ready   = empty || (rsp_ready && final_beat);
   assign rsp_out_byte      = second_ff ? wk_data.byte1 : wk_data.byte0;
   assign rsp_out_valid     = second_ff ? 1'b1 : wk_data.valid0;
   assign rsp_end_of_string = wk_data.eos && final_beat;

   always_ff @(posedge clock) begin
      if (reset) begin
         second_ff <= 1'b0;
      end else if (rsp_valid && rsp_ready) begin
         second_ff <= wk_data.two && !second_ff;
      end
   end

`ifndef ASSERT_OFF
   a_second_only_pair: assert property (@(posedge clock) disable iff (reset)
      second_ff |-> wk_valid && wk_data.two) else $error("stray second beat");
   a_second_follows: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && wk_data.two && !second_ff |=> second_ff)
      else $error("pair lost");
   a_eos_on_final: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_end_of_string |-> final_beat) else $error("early eos");
`endif
endmodule
`default_nettype wire

### rtl/core/charset_byte_display_converter_top.sv
`default_nettype none
// Channel   Direction  Handshake            Payload
// request   in         req_valid/req_ready  req_data_byte, req_last_byte
// result    out        rsp_valid/rsp_ready  rsp_out_byte, rsp_out_valid,
//                                           rsp_end_of_string
// csr       in         csr_write_enable     csr_charset_mode
//
// One request is accepted per cycle while the two-entry queue has room.
// A request yields zero, one or two result beats; two come when it completes
// a Shift-JIS pair or flushes a held byte, and the back then sends both in
// order on the result port before it takes the next entry. The first result of a request
// can leave in the cycle after it is accepted.
// Reset is synchronous and active high; mode returns to ASCII.
// The front and the back stall independently through the queue.
module charset_byte_display_converter_top
   import cbdc_pkg::*;
#(
   parameter int MAX_STRING_BYTES = MaxStringBytes
) (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       csr_write_enable,
   input  wire logic [2:0] csr_charset_mode,
   input  wire logic       req_valid,
   output logic            req_ready,
   input  wire logic [7:0] req_data_byte,
   input  wire logic       req_last_byte,
   output logic            rsp_valid,
   input  wire logic       rsp_ready,
   output logic [7:0]      rsp_out_byte,
   output logic            rsp_out_valid,
   output logic            rsp_end_of_string
);
   // The front converts each request into a queue entry holding its results.
   work_type f_data, b_data;
   logic     f_valid, f_ready, b_valid, b_ready;

   cbdc_front #(.MAX_STRING_BYTES(MAX_STRING_BYTES)) u_front (
      .clock, .reset, .csr_write_enable, .csr_charset_mode,
      .req_valid, .req_ready, .req_data_byte, .req_last_byte,
      .wk_valid(f_valid), .wk_ready(f_ready), .wk_data(f_data)
   );

   cbdc_queue u_queue (
      .clock, .reset,
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_data),
      .out_valid(b_valid), .out_ready(b_ready), .out_data(b_data)
   );

   // The back serializes each entry onto the result port, one byte a cycle while rsp_ready is high.
   cbdc_back u_back (
      .clock, .reset,
      .wk_valid(b_valid), .wk_ready(b_ready), .wk_data(b_data),
      .rsp_valid, .rsp_ready, .rsp_out_byte, .rsp_out_valid, .rsp_end_of_string
   );
endmodule
`default_nettype wire
